// ===== rtl/core/mle_pkg.sv =====
// Shared types, constants and code tables of the Morse lamp encoder.
package mle_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIT,
        S_GAP,
        S_LETTER,
        S_STOP
    } state_t;

    typedef struct packed {
        logic [2:0] count;
        logic [4:0] dashes;
    } morse_code_t;

    localparam int MS_W = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] LAMP_DARK  = 2'd0;
    localparam logic [1:0] LAMP_RED   = 2'd1;
    localparam logic [1:0] LAMP_GREEN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DOT_ON      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_ON     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_GAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LETTER_GAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_ON     = 3'd4;

    localparam logic [MS_W-1:0] DOT_ON_RESET      = 10'd200;
    localparam logic [MS_W-1:0] DASH_ON_RESET     = 10'd500;
    localparam logic [MS_W-1:0] ELEMENT_GAP_RESET = 10'd250;
    localparam logic [MS_W-1:0] LETTER_GAP_RESET  = 10'd350;
    localparam logic [MS_W-1:0] STOP_ON_RESET     = 10'd600;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_STOP  = 8'h2E;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_Z     = 8'h7A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    // Bit i of dashes set means element i is a dash; element 0 is sent first.
    localparam morse_code_t LETTER_TABLE [26] = '{
        '{3'd2, 5'h02}, '{3'd4, 5'h01}, '{3'd4, 5'h05}, '{3'd3, 5'h01},
        '{3'd1, 5'h00}, '{3'd4, 5'h04}, '{3'd3, 5'h03}, '{3'd4, 5'h00},
        '{3'd2, 5'h00}, '{3'd4, 5'h0E}, '{3'd3, 5'h05}, '{3'd4, 5'h02},
        '{3'd2, 5'h03}, '{3'd2, 5'h01}, '{3'd3, 5'h07}, '{3'd4, 5'h06},
        '{3'd4, 5'h0B}, '{3'd3, 5'h02}, '{3'd3, 5'h00}, '{3'd1, 5'h01},
        '{3'd3, 5'h04}, '{3'd4, 5'h08}, '{3'd3, 5'h06}, '{3'd4, 5'h09},
        '{3'd4, 5'h0D}, '{3'd4, 5'h03}
    };

    localparam morse_code_t DIGIT_TABLE [10] = '{
        '{3'd5, 5'h1F}, '{3'd5, 5'h1E}, '{3'd5, 5'h1C}, '{3'd5, 5'h18},
        '{3'd5, 5'h10}, '{3'd5, 5'h00}, '{3'd5, 5'h01}, '{3'd5, 5'h03},
        '{3'd5, 5'h07}, '{3'd5, 5'h0F}
    };

    // A count of zero marks a character that has no Morse code.
    function automatic morse_code_t morse_decode(input logic [7:0] ch);
        logic [7:0] letter_off;
        logic [7:0] digit_off;
        morse_code_t code;
        letter_off = ch - CHAR_A;
        digit_off  = ch - CHAR_0;
        case (ch) inside
            [CHAR_A:CHAR_Z]: code = LETTER_TABLE[letter_off[4:0]];
            [CHAR_0:CHAR_9]: code = DIGIT_TABLE[digit_off[3:0]];
            default:         code = '{3'd0, 5'h00};
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/morse_lamp_encoder.sv =====
// Top level of the Morse lamp encoder: character decode, element sequencer and output register.

// One request on the slave side carries a character; the block answers with one request on
// the master side per lamp segment, tlast marking the final segment of that character. The
// element sequencer produces one segment per cycle while the output register is free, the
// dash pattern shifting out one bit per element. A supported character with n elements yields
// a lit and a dark gap segment per element, then a dark letter gap segment; a full stop yields
// one lit segment, and a space or an ignored character none. A new character is taken only
// when the sequencer is idle; the last segment may still wait in the output register meanwhile.
// Write duration registers through the cfg port only while idle; the block does not enforce it.
module morse_lamp_encoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] character
    input  logic                            s_tuser,   // [0] message_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [1:0] lamp, [11:2] duration_ms, zero pad
    output logic                            m_tlast,   // last_of_run
    input  logic                            cfg_wr_en,
    input  logic [mle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mle_pkg::MS_W-1:0]        cfg_data
);

    mle_pkg::state_t state_reg, state_next;

    logic [mle_pkg::MS_W-1:0] dot_on_reg;
    logic [mle_pkg::MS_W-1:0] dash_on_reg;
    logic [mle_pkg::MS_W-1:0] element_gap_reg;
    logic [mle_pkg::MS_W-1:0] letter_gap_reg;
    logic [mle_pkg::MS_W-1:0] stop_on_reg;

    logic green_reg, green_next;
    logic stopped_reg, stopped_next;
    logic [4:0] pattern_reg, pattern_next;
    logic [2:0] count_reg, count_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [1:0]               lamp_reg, lamp_next;
    logic [mle_pkg::MS_W-1:0] duration_reg, duration_next;
    logic                     last_reg, last_next;

    logic                 accept;
    logic                 out_free;
    logic                 emit;
    logic                 green_eff;
    logic                 stopped_eff;
    mle_pkg::morse_code_t code;
    logic [1:0]           lit_lamp;

    assign s_tready = (state_reg == mle_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = out_free && (state_reg != mle_pkg::S_IDLE);

    // A message start clears colour and stop before this character is looked at.
    assign green_eff   = s_tuser ? 1'b0 : green_reg;
    assign stopped_eff = s_tuser ? 1'b0 : stopped_reg;
    assign code        = mle_pkg::morse_decode(s_tdata);
    assign lit_lamp    = green_reg ? mle_pkg::LAMP_GREEN : mle_pkg::LAMP_RED;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mle_pkg::S_IDLE:
            begin
                if (accept && !stopped_eff)
                begin
                    if (s_tdata == mle_pkg::CHAR_STOP)
                    begin
                        state_next = mle_pkg::S_STOP;
                    end
                    else if (code.count != 3'd0)
                    begin
                        state_next = mle_pkg::S_LIT;
                    end
                end
            end
            mle_pkg::S_LIT:
            begin
                if (emit)
                begin
                    state_next = mle_pkg::S_GAP;
                end
            end
            mle_pkg::S_GAP:
            begin
                if (emit)
                begin
                    state_next = (count_reg == 3'd1) ? mle_pkg::S_LETTER : mle_pkg::S_LIT;
                end
            end
            mle_pkg::S_LETTER,
            mle_pkg::S_STOP:
            begin
                if (emit)
                begin
                    state_next = mle_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mle_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs, colour state and the segment loaded into the output register.
    always_comb
    begin
        green_next    = green_reg;
        stopped_next  = stopped_reg;
        pattern_next  = pattern_reg;
        count_next    = count_reg;
        lamp_next     = lamp_reg;
        duration_next = duration_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        case (state_reg)
            mle_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    green_next   = green_eff;
                    stopped_next = stopped_eff;
                    if (!stopped_eff)
                    begin
                        if (s_tdata == mle_pkg::CHAR_SPACE)
                        begin
                            green_next = !green_eff;
                        end
                        else if (s_tdata == mle_pkg::CHAR_STOP)
                        begin
                            green_next   = !green_eff;
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            pattern_next = code.dashes;
                            count_next   = code.count;
                        end
                    end
                end
            end
            mle_pkg::S_LIT:
            begin
                if (emit)
                begin
                    m_tvalid_next = 1'b1;
                    lamp_next     = lit_lamp;
                    duration_next = pattern_reg[0] ? dash_on_reg : dot_on_reg;
                    last_next     = 1'b0;
                end
            end
            mle_pkg::S_GAP:
            begin
                if (emit)
                begin
                    m_tvalid_next = 1'b1;
                    lamp_next     = mle_pkg::LAMP_DARK;
                    duration_next = element_gap_reg;
                    last_next     = 1'b0;
                    pattern_next  = {1'b0, pattern_reg[4:1]};
                    count_next    = count_reg - 3'd1;
                end
            end
            mle_pkg::S_LETTER:
            begin
                if (emit)
                begin
                    m_tvalid_next = 1'b1;
                    lamp_next     = mle_pkg::LAMP_DARK;
                    duration_next = letter_gap_reg;
                    last_next     = 1'b1;
                end
            end
            mle_pkg::S_STOP:
            begin
                if (emit)
                begin
                    m_tvalid_next = 1'b1;
                    lamp_next     = lit_lamp;
                    duration_next = stop_on_reg;
                    last_next     = 1'b1;
                end
            end
            default:
            begin
                m_tvalid_next = m_tvalid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mle_pkg::S_IDLE;
            green_reg    <= 1'b0;
            stopped_reg  <= 1'b0;
            count_reg    <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            green_reg    <= green_next;
            stopped_reg  <= stopped_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pattern_reg  <= pattern_next;
        lamp_reg     <= lamp_next;
        duration_reg <= duration_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_on_reg      <= mle_pkg::DOT_ON_RESET;
            dash_on_reg     <= mle_pkg::DASH_ON_RESET;
            element_gap_reg <= mle_pkg::ELEMENT_GAP_RESET;
            letter_gap_reg  <= mle_pkg::LETTER_GAP_RESET;
            stop_on_reg     <= mle_pkg::STOP_ON_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mle_pkg::CFG_DOT_ON:      dot_on_reg      <= cfg_data;
                mle_pkg::CFG_DASH_ON:     dash_on_reg     <= cfg_data;
                mle_pkg::CFG_ELEMENT_GAP: element_gap_reg <= cfg_data;
                mle_pkg::CFG_LETTER_GAP:  letter_gap_reg  <= cfg_data;
                mle_pkg::CFG_STOP_ON:     stop_on_reg     <= cfg_data;
                default:                  ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, duration_reg, lamp_reg};
    assign m_tlast  = last_reg;

    // While elements remain to be sent the element counter must not have run out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mle_pkg::S_LIT || state_reg == mle_pkg::S_GAP) |-> (count_reg != 3'd0))
        else $error("element sequencer active with no elements left");

    // The letter gap closes a character: a dark segment flagged last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mle_pkg::S_LETTER && out_free)
        |=> (m_tvalid && m_tlast && m_tdata[1:0] == mle_pkg::LAMP_DARK))
        else $error("letter gap not presented as a dark last segment");

    // A full stop always leaves the message stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mle_pkg::S_STOP) |-> stopped_reg)
        else $error("full stop segment pending without a stopped message");

    // The full stop goes out lit and closes its character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mle_pkg::S_STOP && out_free)
        |=> (m_tvalid && m_tlast && m_tdata[1:0] != mle_pkg::LAMP_DARK))
        else $error("full stop not presented as a lit last segment");

endmodule
